FILE: design/tmc_pkg.sv
// Shared types and constants for the tile map store with text cursor.
// No dependencies; imported by tile_map_store_with_text_cursor_top.
`default_nettype none

package tmc_pkg;

   localparam int OUT_W = 10;                 // width of tile_value_out
   localparam logic [15:0] SPACE_CODE = 16'd32;

   typedef enum logic [2:0] {
      OP_READ       = 3'd0,
      OP_WRITE      = 3'd1,
      OP_FILL_ALL   = 3'd2,
      OP_FILL_ROW   = 3'd3,
      OP_FILL_COL   = 3'd4,
      OP_START_TEXT = 3'd5,
      OP_NEXT_CHAR  = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      CSR_MAP_WIDTH  = 2'd0,
      CSR_MAP_HEIGHT = 2'd1,
      CSR_CHAR_BASE  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      op_type      operation;
      logic [7:0]  col;
      logic [7:0]  row_pos;
      logic [15:0] tile_value_in;
      logic [7:0]  character;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] tile_value_out;
      logic             accepted;
   } rsp_type;

endpackage

`default_nettype wire

FILE: design/tmc_tile_ram.sv
// Single-port tile RAM with registered read data, one access per cycle.
// Used by tile_map_store_with_text_cursor_top; no package dependencies.
`default_nettype none

module tmc_tile_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 10
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic          re,
   input  wire logic [AW-1:0] addr,
   input  wire logic [DW-1:0] wdata,
   output logic      [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: design/tile_map_store_with_text_cursor_top.sv
// Tile map store with text cursor: top level.
// Uses tmc_pkg and tmc_tile_ram.
//
// Usage:
//   req_* carries one operation word (read, write, fill all/row/column,
//   start text, next char); rsp_* returns exactly one result word per
//   request: the tile read (low 10 bits) and an accepted flag.
//   csr_* writes map_width (0), map_height (1) and char_base_tile (2);
//   csr_ready is always high. Write registers only while the block is idle.
// Sequencing:
//   Write, start text, next char and rejected operations: the result is
//   registered at the accept edge. Read: the RAM read data is registered,
//   then loaded into the result register once that register is free.
//   Fills: result is posted at once, then the RAM is swept one entry per
//   cycle: width entries for a row, height for a column, width*height for
//   the whole map; req_stall stays high during the sweep.
// Reset (synchronous): clears the cursor, loads the register defaults and
//   runs a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries (4096 entries
//   at the defaults) with req_stall high; CSR writes are still taken.
// Back-pressure: the result register holds while rsp_stall is high; a new
//   word is taken only when the result register is free or being drained.
`default_nettype none

module tile_map_store_with_text_cursor_top
   import tmc_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int TILE_LIMIT = 1024
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_type       req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_data,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [15:0]   csr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW    = AW + 1;
   localparam int TW    = $clog2(TILE_LIMIT);

   // configuration
   logic [6:0]  map_width_ff, map_height_ff;
   logic [15:0] char_base_ff;

   // control state
   state_type   state_ff, state_in;
   logic [7:0]  cur_col_ff, cur_col_in;
   logic [7:0]  cur_row_ff, cur_row_in;
   logic        cur_live_ff, cur_live_in;
   logic [AW-1:0] sw_addr_ff, sw_addr_in;
   logic [7:0]    sw_step_ff, sw_step_in;
   logic [LW-1:0] sw_left_ff, sw_left_in;
   logic [TW-1:0] sw_tile_ff, sw_tile_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   // datapath
   logic [7:0]  w_eff, h_eff;
   logic        size_ok, in_map, tile_ok, char_ok;
   logic [15:0] char_tile;
   logic [7:0]  mul_x, mul_y;
   logic [15:0] prod_sum;
   logic [AW-1:0] idx;
   logic        fire, rsp_free;

   // decode
   logic        ok, read_go, write_go, sweep_go;
   logic        cursor_set, cursor_clear, cursor_adv;
   logic [15:0] wr_tile;
   logic [AW-1:0] sw_start;
   logic [7:0]    sw_step_new;
   logic [LW-1:0] sw_count;

   // RAM side
   logic          mem_we, mem_re, rsp_load;
   logic [AW-1:0] mem_addr;
   logic [TW-1:0] mem_wdata, mem_rdata;
   logic [15:0]   rd_wide;
   logic [7:0]    col_next, row_next;

   tmc_tile_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (TW)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // ---------------- configuration port ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= 7'd64;
         map_height_ff <= 7'd64;
         char_base_ff  <= 16'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  map_width_ff  <= csr_data[6:0];
            CSR_MAP_HEIGHT: map_height_ff <= csr_data[6:0];
            CSR_CHAR_BASE:  char_base_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- checks and address ----------------
   // sizes above the maximum act as the maximum
   assign w_eff = (9'(map_width_ff) > 9'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : 8'(map_width_ff);
   assign h_eff = (9'(map_height_ff) > 9'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : 8'(map_height_ff);

   assign size_ok   = (w_eff != 8'd0) && (h_eff != 8'd0);
   assign in_map    = (req_data.col < w_eff) && (req_data.row_pos < h_eff);
   assign tile_ok   = {1'b0, req_data.tile_value_in} < 17'(TILE_LIMIT);
   assign char_tile = 16'(req_data.character) - SPACE_CODE + char_base_ff;
   assign char_ok   = (cur_col_ff < w_eff) && (cur_row_ff < h_eff)
                      && ({1'b0, char_tile} < 17'(TILE_LIMIT));

   // one shared multiplier: row-major index, row start, or map size
   always_comb begin
      case (req_data.operation)
         OP_FILL_ALL: begin
            mul_y = h_eff;
            mul_x = 8'd0;
         end
         OP_FILL_ROW: begin
            mul_y = req_data.row_pos;
            mul_x = 8'd0;
         end
         OP_NEXT_CHAR: begin
            mul_y = cur_row_ff;
            mul_x = cur_col_ff;
         end
         default: begin
            mul_y = req_data.row_pos;
            mul_x = req_data.col;
         end
      endcase
   end

   assign prod_sum = 16'(w_eff) * 16'(mul_y) + 16'(mul_x);
   assign idx      = AW'(prod_sum);

   // ---------------- operation decode ----------------
   always_comb begin
      ok           = 1'b0;
      read_go      = 1'b0;
      write_go     = 1'b0;
      sweep_go     = 1'b0;
      cursor_set   = 1'b0;
      cursor_clear = 1'b0;
      cursor_adv   = 1'b0;
      wr_tile      = req_data.tile_value_in;
      sw_start     = idx;
      sw_step_new  = 8'd1;
      sw_count     = LW'(prod_sum);
      if (size_ok) begin
         unique case (req_data.operation)
            OP_READ: begin
               ok      = in_map;
               read_go = in_map;
            end
            OP_WRITE: begin
               ok       = in_map && tile_ok;
               write_go = in_map && tile_ok;
            end
            OP_FILL_ALL: begin
               ok       = tile_ok;
               sweep_go = tile_ok;
               sw_start = '0;
            end
            OP_FILL_ROW: begin
               ok       = (req_data.row_pos < h_eff) && tile_ok;
               sweep_go = (req_data.row_pos < h_eff) && tile_ok;
               sw_count = LW'(w_eff);
            end
            OP_FILL_COL: begin
               ok          = (req_data.col < w_eff) && tile_ok;
               sweep_go    = (req_data.col < w_eff) && tile_ok;
               sw_start    = AW'(req_data.col);
               sw_step_new = w_eff;
               sw_count    = LW'(h_eff);
            end
            OP_START_TEXT: begin
               ok           = in_map;
               cursor_set   = in_map;
               cursor_clear = !in_map;
            end
            OP_NEXT_CHAR: begin
               if (cur_live_ff) begin
                  ok         = char_ok;
                  write_go   = char_ok;
                  wr_tile    = char_tile;
                  cursor_adv = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------- handshake ----------------
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = req_valid && !req_stall;
   assign rd_wide  = 16'(mem_rdata);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (fire && read_go) begin
               state_in = ST_READ;
            end else if (fire && sweep_go) begin
               state_in = ST_SWEEP;
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (sw_left_ff == LW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- FSM outputs ----------------
   always_comb begin
      req_stall  = 1'b1;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = idx;
      mem_wdata  = TW'(wr_tile);
      rsp_load   = 1'b0;
      rsp_in     = rsp_ff;
      sw_addr_in = sw_addr_ff;
      sw_step_in = sw_step_ff;
      sw_left_in = sw_left_ff;
      sw_tile_in = sw_tile_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !rsp_free;
            mem_we    = fire && write_go;
            mem_re    = fire && read_go;
            if (fire && !read_go) begin
               rsp_load                = 1'b1;
               rsp_in.tile_value_out   = '0;
               rsp_in.accepted         = ok;
            end
            if (fire && sweep_go) begin
               sw_addr_in = sw_start;
               sw_step_in = sw_step_new;
               sw_left_in = sw_count;
               sw_tile_in = TW'(req_data.tile_value_in);
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               rsp_load              = 1'b1;
               rsp_in.tile_value_out = rd_wide[OUT_W-1:0];
               rsp_in.accepted       = 1'b1;
            end
         end
         ST_SWEEP: begin
            mem_we     = 1'b1;
            mem_addr   = sw_addr_ff;
            mem_wdata  = sw_tile_ff;
            sw_addr_in = sw_addr_ff + AW'(sw_step_ff);
            sw_left_in = sw_left_ff - LW'(1);
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // ---------------- cursor ----------------
   assign col_next = cur_col_ff + 8'd1;
   assign row_next = cur_row_ff + 8'd1;

   always_comb begin
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      cur_live_in = cur_live_ff;
      if (fire) begin
         if (cursor_set) begin
            cur_col_in  = req_data.col;
            cur_row_in  = req_data.row_pos;
            cur_live_in = 1'b1;
         end else if (cursor_clear) begin
            cur_live_in = 1'b0;
         end else if (cursor_adv) begin
            // step right, wrap to next row, then back to the top
            if (col_next >= w_eff) begin
               cur_col_in = 8'd0;
               cur_row_in = (row_next >= h_eff) ? 8'd0 : row_next;
            end else begin
               cur_col_in = col_next;
            end
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;           // clearing pass
         sw_addr_ff   <= '0;
         sw_step_ff   <= 8'd1;
         sw_left_ff   <= LW'(DEPTH);
         sw_tile_ff   <= '0;
         cur_col_ff   <= 8'd0;
         cur_row_ff   <= 8'd0;
         cur_live_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_addr_ff   <= sw_addr_in;
         sw_step_ff   <= sw_step_in;
         sw_left_ff   <= sw_left_in;
         sw_tile_ff   <= sw_tile_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         cur_live_ff  <= cur_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
